[hw/rtl/htv_pkg.sv]
// types shared by the tone voice modules: configuration bundle,
// sequencer commands and datapath status. no dependencies.
`timescale 1ns / 1ps

package htv_pkg;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [19:0] note_samples;
    logic        loop_mode;
    logic [15:0] period_samples;
  } htv_cfg_t;

  typedef struct packed {
    logic       start;     // input word accepted this cycle
    logic [1:0] harm;      // harmonic being looked up, 0 is the fundamental
    logic       rom_rd;
    logic       w_clr;
    logic       w_acc;
    logic       env_seg;   // pick envelope segment, note flags
    logic       env_num;   // load divider with envelope numerator
    logic       div_mul;
    logic       div_q0;
    logic       div_fin;
    logic       mag_ld;
    logic       out_num;   // load divider with scaled magnitude
    logic       commit;    // write result word, advance index and phase
  } htv_cmd_t;

  typedef struct packed {
    logic out_free;
  } htv_sts_t;

endpackage

[hw/rtl/htv_regs.sv]
// apb-style configuration registers of the tone voice.
// depends on htv_pkg for the configuration bundle.
`timescale 1ns / 1ps

module htv_regs
  import htv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output htv_cfg_t    cfg
);

  localparam logic [1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [1:0] REG_NOTE_SAMPLES   = 2'd1;
  localparam logic [1:0] REG_LOOP_MODE      = 2'd2;
  localparam logic [1:0] REG_PERIOD_SAMPLES = 2'd3;

  localparam logic [31:0] RST_PHASE_STEP     = 32'd42852281;
  localparam logic [19:0] RST_NOTE_SAMPLES   = 20'd13230;
  localparam logic        RST_LOOP_MODE      = 1'b0;
  localparam logic [15:0] RST_PERIOD_SAMPLES = 16'd100;

  logic [1:0] reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step     <= RST_PHASE_STEP;
      cfg.note_samples   <= RST_NOTE_SAMPLES;
      cfg.loop_mode      <= RST_LOOP_MODE;
      cfg.period_samples <= RST_PERIOD_SAMPLES;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_PHASE_STEP:     cfg.phase_step     <= pwdata;
        REG_NOTE_SAMPLES:   cfg.note_samples   <= pwdata[19:0];
        REG_LOOP_MODE:      cfg.loop_mode      <= pwdata[0];
        REG_PERIOD_SAMPLES: cfg.period_samples <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PHASE_STEP:     prdata = cfg.phase_step;
      REG_NOTE_SAMPLES:   prdata = {12'b0, cfg.note_samples};
      REG_LOOP_MODE:      prdata = {31'b0, cfg.loop_mode};
      REG_PERIOD_SAMPLES: prdata = {16'b0, cfg.period_samples};
    endcase
  end

endmodule

[hw/rtl/htv_ctrl.sv]
// sequencer of the tone voice: steps one input word through the
// datapath. depends on htv_pkg for command and status types.
`timescale 1ns / 1ps

module htv_ctrl
  import htv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  htv_sts_t sts,
  output htv_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_H0   = 4'd1;
  localparam logic [3:0] S_H1   = 4'd2;
  localparam logic [3:0] S_H2   = 4'd3;
  localparam logic [3:0] S_H3   = 4'd4;
  localparam logic [3:0] S_H4   = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_T    = 4'd7;
  localparam logic [3:0] S_D1   = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_D3   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_H0;
        end
      end
      S_H0: begin
        cmd.rom_rd  = 1'b1;
        cmd.harm    = 2'd0;
        cmd.w_clr   = 1'b1;
        cmd.env_seg = 1'b1;
        state_next  = S_H1;
      end
      S_H1: begin
        cmd.rom_rd  = 1'b1;
        cmd.harm    = 2'd1;
        cmd.w_acc   = 1'b1;
        cmd.env_num = 1'b1;
        state_next  = S_H2;
      end
      S_H2: begin
        cmd.rom_rd  = 1'b1;
        cmd.harm    = 2'd2;
        cmd.w_acc   = 1'b1;
        cmd.div_mul = 1'b1;
        state_next  = S_H3;
      end
      S_H3: begin
        cmd.rom_rd  = 1'b1;
        cmd.harm    = 2'd3;
        cmd.w_acc   = 1'b1;
        cmd.div_q0  = 1'b1;
        state_next  = S_H4;
      end
      S_H4: begin
        cmd.w_acc   = 1'b1;
        cmd.div_fin = 1'b1;
        state_next  = S_MAG;
      end
      S_MAG: begin
        cmd.mag_ld = 1'b1;
        state_next = S_T;
      end
      S_T: begin
        cmd.out_num = 1'b1;
        state_next  = S_D1;
      end
      S_D1: begin
        cmd.div_mul = 1'b1;
        state_next  = S_D2;
      end
      S_D2: begin
        cmd.div_q0 = 1'b1;
        state_next = S_D3;
      end
      S_D3: begin
        cmd.div_fin = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/htv_dp.sv]
// datapath of the tone voice: index and phase state, quarter-wave sine
// table, harmonic accumulator, envelope, shared constant divider and
// output register. depends on htv_pkg.
`timescale 1ns / 1ps

module htv_dp
  import htv_pkg::*;
#(
  parameter int SINE_ADDR_BITS = 10,
  parameter int INDEX_BITS     = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  htv_cfg_t           cfg,
  input  htv_cmd_t           cmd,
  input  logic               restart,
  output htv_sts_t           sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               active,
  output logic               last
);

  localparam int QB    = SINE_ADDR_BITS - 2;
  localparam int QSIZE = 1 << QB;
  localparam logic [QB:0] QFULL = {1'b1, {QB{1'b0}}};

  localparam longint ONE_Q30 = 64'sd1073741824;

  // compare width, covers index plus envelope offsets
  localparam int CW = ((INDEX_BITS > 20) ? INDEX_BITS : 20) + 2;

  localparam int AUDIO_HZ = 44100;
  localparam int ATT_LEN = AUDIO_HZ * 10 / 1000;
  localparam int DEC_LEN = AUDIO_HZ * 100 / 1000;
  localparam int REL_LEN = AUDIO_HZ * 200 / 1000;

  localparam logic [CW-1:0] ATT_C   = CW'(ATT_LEN);
  localparam logic [CW-1:0] DEC_END = CW'(ATT_LEN + DEC_LEN);
  localparam logic [CW-1:0] REL_C   = CW'(REL_LEN);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [16:0] ENV_ONE  = 17'd65536;
  localparam logic [16:0] ENV_SUS  = 17'd39322;
  localparam logic [15:0] DEC_GAIN = 16'd26214;  // one minus sustain level
  localparam logic [15:0] REL_GAIN = 16'd39322;

  localparam logic [2:0] SEG_FULL = 3'd0;
  localparam logic [2:0] SEG_ATT  = 3'd1;
  localparam logic [2:0] SEG_DEC  = 3'd2;
  localparam logic [2:0] SEG_SUS  = 3'd3;
  localparam logic [2:0] SEG_REL  = 3'd4;

  localparam logic [1:0] DIV_50  = 2'd0;
  localparam logic [1:0] DIV_ATT = 2'd1;
  localparam logic [1:0] DIV_DEC = 2'd2;
  localparam logic [1:0] DIV_REL = 2'd3;

  localparam int DIV_SHIFT = 30;
  localparam logic [24:0] K_50  = 25'((1 << DIV_SHIFT) / 50);
  localparam logic [24:0] K_ATT = 25'((1 << DIV_SHIFT) / ATT_LEN);
  localparam logic [24:0] K_DEC = 25'((1 << DIV_SHIFT) / DEC_LEN);
  localparam logic [24:0] K_REL = 25'((1 << DIV_SHIFT) / REL_LEN);

  localparam logic [20:0] RND_HALF  = 21'd1638400;  // 50 * 32768
  localparam logic [14:0] MAX_Q15   = 15'd32767;

  // quarter-wave magnitude, odd taylor polynomial in q30
  function automatic logic [14:0] sine_mag(input int m);
    longint u;
    longint u2;
    longint acc;
    longint v;
    u   = longint'(m) <<< (30 - QB);
    u2  = (u * u) / ONE_Q30;
    acc = 64'sd172271;
    acc = -64'sd5026989 + (acc * u2) / ONE_Q30;
    acc = 64'sd85569306 + (acc * u2) / ONE_Q30;
    acc = -64'sd693598669 + (acc * u2) / ONE_Q30;
    acc = 64'sd1686629713 + (acc * u2) / ONE_Q30;
    acc = (acc * u) / ONE_Q30;
    if (acc < 0) acc = 0;
    v = (acc * 32767 + (ONE_Q30 / 2)) / ONE_Q30;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  logic [14:0] qtab [QSIZE+1];

  for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
    localparam logic [14:0] QV = sine_mag(g);
    assign qtab[g] = QV;
  end

  // index and phase state
  logic [INDEX_BITS-1:0] sample_index;
  logic [31:0]           phase_acc;

  // harmonic lookup
  logic [31:0]               ph;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QB:0]               qm;
  logic [14:0]               rom_mag;
  logic                      rom_neg;
  logic [1:0]                harm_d;
  logic [17:0]               shv;
  logic signed [19:0]        term;
  logic signed [19:0]        w;
  logic [19:0]               w_negv;
  logic [18:0]               w_abs;

  // envelope and flags
  logic [CW-1:0] ie;
  logic [CW-1:0] ne;
  logic [CW-1:0] pe;
  logic [CW-1:0] dec_off;
  logic [CW-1:0] rel_rem;
  logic [2:0]    seg_c;
  logic [13:0]   x_c;
  logic          act_c;
  logic          lst_c;
  logic [2:0]    seg;
  logic [13:0]   env_x;
  logic          act_r;
  logic          lst_r;
  logic          wrap_r;
  logic [15:0]   gain;
  logic [29:0]   xg;
  logic [16:0]   env;

  // magnitude and rounding
  logic [35:0] mag;
  logic [36:0] tsum;
  logic [20:0] tval;
  logic        clamp;

  // constant divider
  logic [28:0] div_num;
  logic [1:0]  div_sel;
  logic [24:0] div_k;
  logic [13:0] div_d;
  logic [53:0] div_prod;
  logic [23:0] div_q0v;
  logic [37:0] qd_full;
  logic [28:0] div_qd;
  logic [28:0] div_r;
  logic [23:0] div_q;

  // result
  logic [14:0] qmag;
  logic [15:0] qx;
  logic [15:0] qn;

  // harmonic k phase is k times the accumulator
  always_comb begin
    unique case (cmd.harm)
      2'd0: ph = phase_acc;
      2'd1: ph = {phase_acc[30:0], 1'b0};
      2'd2: ph = phase_acc + {phase_acc[30:0], 1'b0};
      2'd3: ph = {phase_acc[29:0], 2'b0};
    endcase
  end

  assign addr = ph[31 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign qm   = quad[0] ? (QFULL - {1'b0, addr[QB-1:0]}) : {1'b0, addr[QB-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      rom_mag <= qtab[qm];
      rom_neg <= quad[1];
      harm_d  <= cmd.harm;
    end
  end

  // weights 8, 4, 2, 1
  assign shv  = {3'b0, rom_mag} << (2'd3 - harm_d);
  assign term = rom_neg ? -$signed({2'b0, shv}) : $signed({2'b0, shv});

  always_ff @(posedge clk) begin
    if (cmd.w_clr) begin
      w <= '0;
    end else if (cmd.w_acc) begin
      w <= w + term;
    end
  end

  assign w_negv = -w;
  assign w_abs  = w[19] ? w_negv[18:0] : w[18:0];

  // envelope segment and note flags
  assign ie      = {{(CW-INDEX_BITS){1'b0}}, sample_index};
  assign ne      = {{(CW-20){1'b0}}, cfg.note_samples};
  assign pe      = {{(CW-16){1'b0}}, cfg.period_samples};
  assign dec_off = ie - ATT_C;
  assign rel_rem = ne - ie;

  always_comb begin
    x_c = '0;
    if (cfg.loop_mode) begin
      seg_c = SEG_FULL;
      act_c = 1'b1;
      lst_c = ((ie + ONE_C) >= pe);
    end else begin
      act_c = (ie < ne);
      lst_c = act_c && ((ie + ONE_C) == ne);
      priority if (ie < ATT_C) begin
        seg_c = SEG_ATT;
        x_c   = ie[13:0];
      end else if (ie < DEC_END) begin
        seg_c = SEG_DEC;
        x_c   = dec_off[13:0];
      end else if ((ie + REL_C) < ne) begin
        seg_c = SEG_SUS;
      end else begin
        // remaining samples of the note, at most the release length
        seg_c = SEG_REL;
        x_c   = rel_rem[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.env_seg) begin
      seg    <= seg_c;
      env_x  <= x_c;
      act_r  <= act_c;
      lst_r  <= lst_c;
      wrap_r <= cfg.loop_mode && lst_c;
    end
  end

  assign gain = (seg == SEG_DEC) ? DEC_GAIN : REL_GAIN;
  assign xg   = {16'b0, env_x} * {14'b0, gain};

  always_comb begin
    case (seg)
      SEG_ATT: env = div_q[16:0];
      SEG_DEC: env = ENV_ONE - div_q[16:0];
      SEG_SUS: env = ENV_SUS;
      SEG_REL: env = div_q[16:0];
      default: env = ENV_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      mag <= {17'b0, w_abs} * {19'b0, env};
    end
  end

  assign tsum  = {1'b0, mag} + {16'b0, RND_HALF};
  assign tval  = tsum[36:16];

  always_ff @(posedge clk) begin
    if (cmd.out_num) begin
      clamp <= (tval >= RND_HALF);
    end
  end

  // divider: reciprocal multiply, then one correction step
  always_ff @(posedge clk) begin
    if (cmd.env_num) begin
      div_num <= (seg == SEG_ATT) ? {env_x[12:0], 16'b0} : xg[28:0];
      unique case (seg)
        SEG_ATT: div_sel <= DIV_ATT;
        SEG_DEC: div_sel <= DIV_DEC;
        default: div_sel <= DIV_REL;
      endcase
    end else if (cmd.out_num) begin
      div_num <= {8'b0, tval};
      div_sel <= DIV_50;
    end
  end

  always_comb begin
    unique case (div_sel)
      DIV_50: begin
        div_k = K_50;
        div_d = 14'd50;
      end
      DIV_ATT: begin
        div_k = K_ATT;
        div_d = 14'(ATT_LEN);
      end
      DIV_DEC: begin
        div_k = K_DEC;
        div_d = 14'(DEC_LEN);
      end
      DIV_REL: begin
        div_k = K_REL;
        div_d = 14'(REL_LEN);
      end
    endcase
  end

  assign qd_full = {14'b0, div_prod[53:30]} * {24'b0, div_d};
  assign div_r   = div_num - div_qd;

  always_ff @(posedge clk) begin
    if (cmd.div_mul) begin
      div_prod <= {25'b0, div_num} * {29'b0, div_k};
    end
    if (cmd.div_q0) begin
      div_q0v <= div_prod[53:30];
      div_qd  <= qd_full[28:0];
    end
    if (cmd.div_fin) begin
      div_q <= div_q0v + {23'b0, (div_r >= {15'b0, div_d})};
    end
  end

  // result and state advance
  assign qmag = clamp ? MAX_Q15 : div_q[14:0];
  assign qx   = {1'b0, qmag};
  assign qn   = ~qx + 16'd1;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample <= act_r ? $signed(w[19] ? qn : qx) : 16'sd0;
      active <= act_r;
      last   <= lst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase_acc    <= '0;
    end else if (cmd.start && restart) begin
      sample_index <= '0;
      phase_acc    <= '0;
    end else if (cmd.commit) begin
      if (wrap_r) begin
        sample_index <= '0;
        phase_acc    <= '0;
      end else if (act_r) begin
        sample_index <= sample_index + {{(INDEX_BITS-1){1'b0}}, 1'b1};
        phase_acc    <= phase_acc + cfg.phase_step;
      end
    end
  end

endmodule

[hw/rtl/harmonic_tone_voice_adsr.sv]
// additive tone voice with adsr envelope, one q1.15 sample per input word.
// a new input word is taken only once the previous result word has been
// committed to the output register; each word takes four reads of the shared
// sine table and two passes through the shared constant divider.
// reset: registers return to their defaults, index and phase clear to zero.
// depends on htv_pkg, htv_regs, htv_ctrl, htv_dp.
`timescale 1ns / 1ps

module harmonic_tone_voice_adsr
  import htv_pkg::*;
#(
  parameter int SINE_ADDR_BITS = 10,
  parameter int INDEX_BITS     = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               active,
  output logic               last
);

  htv_cfg_t cfg;
  htv_cmd_t cmd;
  htv_sts_t sts;

  htv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  htv_dp #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .INDEX_BITS     (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .restart   (restart),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .active    (active),
    .last      (last)
  );

endmodule
